@@ hw/rtl/bis_pkg.sv @@
package bis_pkg;

    localparam int STORE_DEPTH = 65536;
    localparam int ADDR_W      = 16;
    localparam int CFG_W       = 9;
    localparam int VALUE_W     = 24;
    localparam int WEIGHT_FRAC = 16;
    localparam int ROUND_SHIFT = 8;
    localparam int QUEUE_DEPTH = 4;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic CFG_ROW_WIDTH = 1'b0;
    localparam logic CFG_ROW_COUNT = 1'b1;

    localparam logic [CFG_W-1:0] ROW_WIDTH_RESET = 9'd256;
    localparam logic [CFG_W-1:0] ROW_COUNT_RESET = 9'd256;

    typedef struct packed {
        logic               func;
        logic [15:0]        pixel_index;
        logic signed [15:0] pixel_value;
        logic [15:0]        x_coord;
        logic [15:0]        y_coord;
        logic               batch_end;
    } cmd_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] interp_value;
        logic                      out_of_range;
        logic                      batch_last;
    } res_item_t;

    // classified item; fractions are zero-extended to 16 bits
    typedef struct packed {
        logic               func;
        logic [ADDR_W-1:0]  addr00;
        logic [ADDR_W-1:0]  addr10;
        logic [ADDR_W-1:0]  addr01;
        logic [ADDR_W-1:0]  addr11;
        logic signed [15:0] pixel_value;
        logic [15:0]        frac_x;
        logic [15:0]        frac_y;
        logic               out_of_range;
        logic               batch_last;
    } q_item_t;

endpackage

@@ hw/rtl/bis_ram.sv @@
module bis_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

@@ hw/rtl/bis_front.sv @@
module bis_front
    import bis_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  cmd_item_t        cmd,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output logic             push,
    output q_item_t          push_item,
    input  logic             q_full
);

    logic [CFG_W-1:0] row_width_reg;
    logic [CFG_W-1:0] row_count_reg;

    logic [CFG_W-1:0] wdt;
    logic [CFG_W-1:0] hgt;
    logic [15:0]      x0;
    logic [15:0]      y0;
    logic [24:0]      prod_full;
    logic             edge_hit;
    logic             accept;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               s1_func_reg;
    logic [15:0]        s1_index_reg;
    logic signed [15:0] s1_value_reg;
    logic [15:0]        s1_x0_reg;
    logic [15:0]        s1_fx_reg;
    logic [15:0]        s1_fy_reg;
    logic               s1_last_reg;
    logic               s1_oor_reg;
    logic [ADDR_W-1:0]  s1_prod_reg;
    logic [ADDR_W-1:0]  s1_wdt_reg;
    logic [ADDR_W-1:0]  s1_wdt1_reg;

    logic [ADDR_W-1:0] base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_WIDTH_RESET;
            row_count_reg <= ROW_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROW_WIDTH: row_width_reg <= cfg_data;
                CFG_ROW_COUNT: row_count_reg <= cfg_data;
                default:       row_width_reg <= row_width_reg;
            endcase
        end
    end

    // registers are saturated into the legal range at use
    always_comb
    begin
        if (row_width_reg < 9'd2)
            wdt = 9'd2;
        else if (int'(row_width_reg) > MAX_WIDTH)
            wdt = CFG_W'(MAX_WIDTH);
        else
            wdt = row_width_reg;

        if (row_count_reg < 9'd2)
            hgt = 9'd2;
        else if (int'(row_count_reg) > MAX_HEIGHT)
            hgt = CFG_W'(MAX_HEIGHT);
        else
            hgt = row_count_reg;
    end

    assign x0        = cmd.x_coord >> FRAC_BITS;
    assign y0        = cmd.y_coord >> FRAC_BITS;
    assign prod_full = 25'(y0) * 25'(wdt);
    assign edge_hit  = (17'(x0) + 17'd1 >= 17'(wdt)) || (17'(y0) + 17'd1 >= 17'(hgt));

    assign push      = s1_valid_reg && !q_full;
    assign cmd_ready = !s1_valid_reg || !q_full;
    assign accept    = cmd_valid && cmd_ready;

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (push)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg  <= cmd.func;
            s1_index_reg <= cmd.pixel_index;
            s1_value_reg <= cmd.pixel_value;
            s1_x0_reg    <= x0;
            s1_fx_reg    <= 16'(cmd.x_coord[FRAC_BITS-1:0]);
            s1_fy_reg    <= 16'(cmd.y_coord[FRAC_BITS-1:0]);
            s1_last_reg  <= cmd.batch_end;
            s1_oor_reg   <= edge_hit;
            s1_prod_reg  <= prod_full[ADDR_W-1:0];
            s1_wdt_reg   <= ADDR_W'(wdt);
            s1_wdt1_reg  <= ADDR_W'(wdt) + 16'd1;
        end
    end

    // store addresses wrap modulo the store depth
    assign base = s1_prod_reg + s1_x0_reg;

    always_comb
    begin
        push_item.func         = s1_func_reg;
        push_item.addr00       = (s1_func_reg == FUNC_LOAD) ? s1_index_reg : base;
        push_item.addr10       = base + 16'd1;
        push_item.addr01       = base + s1_wdt_reg;
        push_item.addr11       = base + s1_wdt1_reg;
        push_item.pixel_value  = s1_value_reg;
        push_item.frac_x       = s1_fx_reg;
        push_item.frac_y       = s1_fy_reg;
        push_item.out_of_range = s1_oor_reg;
        push_item.batch_last   = s1_last_reg;
    end

endmodule

@@ hw/rtl/bis_queue.sv @@
module bis_queue
    import bis_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  q_item_t push_item,
    output logic    full,
    input  logic    pop,
    output q_item_t head,
    output logic    empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    q_item_t         entries_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue read while empty");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("queue fill count lost a push");

endmodule

@@ hw/rtl/bis_back.sv @@
module bis_back
    import bis_pkg::*;
#(
    parameter int FRAC_BITS  = 8,
    parameter int PIXEL_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  q_item_t   head,
    output logic      pop,
    output logic      res_valid,
    input  logic      res_ready,
    output res_item_t res
);

    localparam int SPB    = (PIXEL_BITS >= 16) ? 16 : PIXEL_BITS;
    localparam int WSH_R  = (2 * FRAC_BITS >= WEIGHT_FRAC) ? 2 * FRAC_BITS - WEIGHT_FRAC : 0;
    localparam int WSH_L  = (2 * FRAC_BITS < WEIGHT_FRAC) ? WEIGHT_FRAC - 2 * FRAC_BITS : 0;
    localparam int W_W    = WEIGHT_FRAC + 1;
    localparam int PROD_W = SPB + W_W + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1 << (ROUND_SHIFT - 1));
    localparam logic signed [SUM_W-1:0] VAL_MAX    = SUM_W'((1 << (VALUE_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] VAL_MIN    = SUM_W'(-(1 << (VALUE_W - 1)));

    function automatic logic [W_W-1:0] weight_q16(logic [FRAC_BITS:0] a, logic [FRAC_BITS:0] b);
        logic [2*FRAC_BITS+1:0] p;
        logic [33:0]            pe;
        begin
            p  = a * b;
            pe = 34'(p);
            return W_W'((pe << WSH_L) >> WSH_R);
        end
    endfunction

    logic advance;
    logic ram_we;
    logic ram_re;

    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
    logic [FRAC_BITS:0]   fx1;
    logic [FRAC_BITS:0]   fy1;

    logic [SPB-1:0] rd00;
    logic [SPB-1:0] rd10;
    logic [SPB-1:0] rd01;
    logic [SPB-1:0] rd11;

    // read issue / weights
    logic           b1_valid_reg;
    logic           b1_oor_reg;
    logic           b1_last_reg;
    logic [W_W-1:0] b1_w00_reg;
    logic [W_W-1:0] b1_w10_reg;
    logic [W_W-1:0] b1_w01_reg;
    logic [W_W-1:0] b1_w11_reg;

    // weighted pixels
    logic                     b2_valid_reg;
    logic                     b2_oor_reg;
    logic                     b2_last_reg;
    logic signed [PROD_W-1:0] b2_p00_reg;
    logic signed [PROD_W-1:0] b2_p10_reg;
    logic signed [PROD_W-1:0] b2_p01_reg;
    logic signed [PROD_W-1:0] b2_p11_reg;

    // pair sums
    logic                    b3_valid_reg;
    logic                    b3_oor_reg;
    logic                    b3_last_reg;
    logic signed [SUM_W-1:0] b3_lo_reg;
    logic signed [SUM_W-1:0] b3_hi_reg;

    logic      out_valid_reg;
    logic      out_valid_next;
    res_item_t out_item_reg;
    res_item_t out_item_next;

    logic signed [SUM_W-1:0] rounded;
    logic signed [SUM_W-1:0] shifted;
    logic signed [SUM_W-1:0] sat;

    function automatic logic signed [PROD_W-1:0] mul_px(logic [SPB-1:0] px, logic [W_W-1:0] w);
        logic signed [PROD_W-1:0] px_e;
        logic signed [PROD_W-1:0] w_e;
        begin
            px_e = PROD_W'($signed(px));
            w_e  = PROD_W'($signed({1'b0, w}));
            return px_e * w_e;
        end
    endfunction

    assign advance = !(out_valid_reg && !res_ready);
    assign pop     = advance && !q_empty;
    assign ram_we  = pop && (head.func == FUNC_LOAD);
    assign ram_re  = pop && (head.func == FUNC_SAMPLE);

    // two copies of the store, each with two read ports, give all four neighbors at once
    bis_ram #(
        .WIDTH (SPB),
        .DEPTH (STORE_DEPTH)
    ) u_ram_top (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (head.addr00),
        .wdata   (head.pixel_value[SPB-1:0]),
        .re      (ram_re),
        .raddr_a (head.addr00),
        .raddr_b (head.addr10),
        .rdata_a (rd00),
        .rdata_b (rd10)
    );

    bis_ram #(
        .WIDTH (SPB),
        .DEPTH (STORE_DEPTH)
    ) u_ram_bot (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (head.addr00),
        .wdata   (head.pixel_value[SPB-1:0]),
        .re      (ram_re),
        .raddr_a (head.addr01),
        .raddr_b (head.addr11),
        .rdata_a (rd01),
        .rdata_b (rd11)
    );

    assign fx  = head.frac_x[FRAC_BITS-1:0];
    assign fy  = head.frac_y[FRAC_BITS-1:0];
    assign fx1 = ONE - {1'b0, fx};
    assign fy1 = ONE - {1'b0, fy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                b1_valid_reg <= ram_re;
                b2_valid_reg <= b1_valid_reg;
                b3_valid_reg <= b2_valid_reg;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b1_oor_reg  <= head.out_of_range;
            b1_last_reg <= head.batch_last;
            b1_w00_reg  <= weight_q16(fx1, fy1);
            b1_w10_reg  <= weight_q16({1'b0, fx}, fy1);
            b1_w01_reg  <= weight_q16(fx1, {1'b0, fy});
            b1_w11_reg  <= weight_q16({1'b0, fx}, {1'b0, fy});

            b2_oor_reg  <= b1_oor_reg;
            b2_last_reg <= b1_last_reg;
            b2_p00_reg  <= mul_px(rd00, b1_w00_reg);
            b2_p10_reg  <= mul_px(rd10, b1_w10_reg);
            b2_p01_reg  <= mul_px(rd01, b1_w01_reg);
            b2_p11_reg  <= mul_px(rd11, b1_w11_reg);

            b3_oor_reg  <= b2_oor_reg;
            b3_last_reg <= b2_last_reg;
            b3_lo_reg   <= SUM_W'(b2_p00_reg) + SUM_W'(b2_p10_reg);
            b3_hi_reg   <= SUM_W'(b2_p01_reg) + SUM_W'(b2_p11_reg);

            out_item_reg <= out_item_next;
        end
    end

    // round half up, then floor shift
    assign rounded = b3_lo_reg + b3_hi_reg + ROUND_HALF;
    assign shifted = rounded >>> ROUND_SHIFT;

    always_comb
    begin
        if (shifted > VAL_MAX)
            sat = VAL_MAX;
        else if (shifted < VAL_MIN)
            sat = VAL_MIN;
        else
            sat = shifted;

        out_item_next.interp_value = b3_oor_reg ? '0 : VALUE_W'(sat);
        out_item_next.out_of_range = b3_oor_reg;
        out_item_next.batch_last   = b3_last_reg;

        out_valid_next = advance ? b3_valid_reg : out_valid_reg;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_item_reg;

    a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("store written and read by the same item");

    a_read_before_weigh: assert property (@(posedge clk) disable iff (!rst_n)
        (b1_valid_reg && $past(advance)) |-> $past(ram_re))
        else $error("weighting stage holds a sample without a store read");

    a_edge_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.out_of_range) |-> (out_item_reg.interp_value == '0))
        else $error("edge sample returned a nonzero value");

endmodule

@@ hw/rtl/bilinear_image_sampler.sv @@
// channel   direction  handshake              payload
// cmd       in         cmd_valid / cmd_ready  cmd_item_t: load or sample item
// res       out        res_valid / res_ready  res_item_t: one per sample item
// cfg       in         cfg_we                 cfg_index, cfg_data (row_width, row_count)
//
// sustained rate is one item per cycle, loads and samples alike, while res_ready does not stall the back end
// a sample result shows on res_valid once the item has passed the classify stage,
// queue, store read, weighting multiply, pair add, then round into the output register
// reset clears control state only; the image store has no clearing pass
// a stalled result holds the back end, while the queue keeps taking items until full
module bilinear_image_sampler
    import bis_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 8,
    parameter int PIXEL_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  cmd_item_t        cmd,
    output logic             res_valid,
    input  logic             res_ready,
    output res_item_t        res,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    logic    push;
    q_item_t push_item;
    logic    q_full;
    logic    q_empty;
    logic    pop;
    q_item_t head;

    bis_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    bis_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty)
    );

    bis_back #(
        .FRAC_BITS  (FRAC_BITS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head      (head),
        .pop       (pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

@@ verif/bis_checker.sv @@
`timescale 1ns / 100ps

module bis_checker
    import bis_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  logic             cmd_ready,
    input  cmd_item_t        cmd,
    input  logic             res_valid,
    input  logic             res_ready,
    input  res_item_t        res,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output int               fail_count,
    output int               pending
);

    logic signed [15:0] pixel_mem [STORE_DEPTH];
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    res_item_t          sample_results_q [$];

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v < 2)
            return 2;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic longint pixel_at(input int unsigned a);
        logic [ADDR_W-1:0] idx;
        idx = a[ADDR_W-1:0];
        return longint'(pixel_mem[idx]);
    endfunction

    // product of two fractions, brought to 16 fraction bits
    function automatic longint q16_weight(input int unsigned a, input int unsigned b);
        longint w;
        w = longint'(a) * longint'(b);
        if (2 * FRAC_BITS >= WEIGHT_FRAC)
            return w >> (2 * FRAC_BITS - WEIGHT_FRAC);
        return w << (WEIGHT_FRAC - 2 * FRAC_BITS);
    endfunction

    function automatic res_item_t interpolate(input cmd_item_t c);
        res_item_t   r;
        int unsigned w, h, x0, y0, fx, fy, gx, gy, base;
        longint      acc, rounded;
        r = '0;
        r.batch_last = c.batch_end;
        w = clamp_dim(32'(width_reg), MAX_WIDTH);
        h = clamp_dim(32'(height_reg), MAX_HEIGHT);
        x0 = 32'(c.x_coord) >> FRAC_BITS;
        y0 = 32'(c.y_coord) >> FRAC_BITS;
        fx = 32'(c.x_coord) & ((1 << FRAC_BITS) - 1);
        fy = 32'(c.y_coord) & ((1 << FRAC_BITS) - 1);
        gx = (1 << FRAC_BITS) - fx;
        gy = (1 << FRAC_BITS) - fy;
        // right or lower neighbor off the image
        if (x0 + 1 >= w || y0 + 1 >= h)
        begin
            r.out_of_range = 1'b1;
            return r;
        end
        base = y0 * w + x0;
        acc = pixel_at(base) * q16_weight(gx, gy)
            + pixel_at(base + 1) * q16_weight(fx, gy)
            + pixel_at(base + w) * q16_weight(gx, fy)
            + pixel_at(base + w + 1) * q16_weight(fx, fy);
        // floor of (acc + half) keeps ties going up
        rounded = (acc + (1 << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
        if (rounded > 64'sd8388607)
            rounded = 64'sd8388607;
        if (rounded < -64'sd8388608)
            rounded = -64'sd8388608;
        r.interp_value = rounded[VALUE_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_item_t want;
        if (!rst_n)
        begin
            width_reg  = ROW_WIDTH_RESET;
            height_reg = ROW_COUNT_RESET;
            sample_results_q.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_ROW_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
            end

            if (res_valid && res_ready)
            begin
                if (sample_results_q.size() == 0)
                begin
                    fail_count++;
                    $display({"%0t: unexpected result: expected none, ",
                              "actual value %0d oor %0b last %0b"},
                             $time, res.interp_value, res.out_of_range, res.batch_last);
                end
                else
                begin
                    want = sample_results_q.pop_front();
                    if (res.interp_value !== want.interp_value)
                    begin
                        fail_count++;
                        $display("%0t: interp_value expected %0d actual %0d",
                                 $time, want.interp_value, res.interp_value);
                    end
                    if (res.out_of_range !== want.out_of_range)
                    begin
                        fail_count++;
                        $display("%0t: out_of_range expected %0b actual %0b",
                                 $time, want.out_of_range, res.out_of_range);
                    end
                    if (res.batch_last !== want.batch_last)
                    begin
                        fail_count++;
                        $display("%0t: batch_last expected %0b actual %0b",
                                 $time, want.batch_last, res.batch_last);
                    end
                end
            end

            if (cmd_valid && cmd_ready)
            begin
                if (cmd.func == FUNC_LOAD)
                    pixel_mem[cmd.pixel_index] = cmd.pixel_value;
                else
                    sample_results_q.push_back(interpolate(cmd));
            end

            pending = sample_results_q.size();
        end
    end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import bis_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             cmd_valid;
    logic             cmd_ready;
    cmd_item_t        cmd;
    logic             res_valid;
    logic             res_ready;
    res_item_t        res;
    logic             cfg_we;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;
    int               fail_count;
    int               pending;

    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles;
    int          sent_count;
    int unsigned cur_w;
    int unsigned cur_h;
    bit          written [STORE_DEPTH];

    // register values per phase, out-of-range ones included
    int unsigned shape_w [8] = '{2, 0, 5, 256, 511, 17, 1, 40};
    int unsigned shape_h [8] = '{2, 1, 3, 2, 300, 9, 256, 31};

    bilinear_image_sampler dut (.*);

    bis_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb failed");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        res_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                res_ready <= 1'b0;
            end
            else
                res_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic int unsigned span(input int unsigned v, input int unsigned hi);
        if (v < 2)
            return 2;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic cmd_item_t rand_cmd();
        cmd_item_t it;
        it.func        = 1'($urandom_range(1));
        it.pixel_index = 16'($urandom);
        it.pixel_value = 16'($urandom);
        it.x_coord     = 16'($urandom);
        it.y_coord     = 16'($urandom);
        it.batch_end   = 1'($urandom_range(1));
        return it;
    endfunction

    task automatic push_cmd(input cmd_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd       <= it;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic load_pixel(input logic [15:0] addr, input logic [15:0] value);
        cmd_item_t it;
        it = rand_cmd();
        it.func        = FUNC_LOAD;
        it.pixel_index = addr;
        it.pixel_value = value;
        written[addr]  = 1'b1;
        push_cmd(it);
    endtask

    // loads any neighbor not yet written, then sends the sample
    task automatic sample_at(input logic [15:0] xc, input logic [15:0] yc, input logic last);
        int unsigned x0, y0, base;
        logic [15:0] nbr [4];
        cmd_item_t   it;
        x0 = 32'(xc[15:8]);
        y0 = 32'(yc[15:8]);
        if (x0 + 1 < cur_w && y0 + 1 < cur_h)
        begin
            base = y0 * cur_w + x0;
            nbr[0] = 16'(base);
            nbr[1] = 16'(base + 1);
            nbr[2] = 16'(base + cur_w);
            nbr[3] = 16'(base + cur_w + 1);
            foreach (nbr[i])
                if (!written[nbr[i]])
                    load_pixel(nbr[i], 16'($urandom));
        end
        it = rand_cmd();
        it.func      = FUNC_SAMPLE;
        it.x_coord   = xc;
        it.y_coord   = yc;
        it.batch_end = last;
        push_cmd(it);
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // loads leave no result; let the pipeline empty
        repeat (12) @(posedge clk);
    endtask

    task automatic set_shape(input int unsigned w, input int unsigned h);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ROW_WIDTH;
        cfg_data  <= CFG_W'(w);
        @(posedge clk);
        cfg_index <= CFG_ROW_COUNT;
        cfg_data  <= CFG_W'(h);
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_w = span(w & 32'h1FF, 256);
        cur_h = span(h & 32'h1FF, 256);
    endtask

    task automatic run_directed();
        // all four neighbors at the negative extreme
        load_pixel(16'd0, 16'h8000);
        load_pixel(16'd1, 16'h8000);
        load_pixel(16'd256, 16'h8000);
        load_pixel(16'd257, 16'h8000);
        sample_at(16'h0080, 16'h0080, 1'b0);
        sample_at(16'h0000, 16'h0000, 1'b1);
        // far corner at the positive extreme
        load_pixel(16'd65278, 16'h7FFF);
        load_pixel(16'd65279, 16'h7FFF);
        load_pixel(16'd65534, 16'h7FFF);
        load_pixel(16'd65535, 16'h7FFF);
        sample_at(16'hFE00, 16'hFE00, 1'b0);
        sample_at(16'hFEFF, 16'hFEFF, 1'b1);
        // mixed signs, small magnitudes
        load_pixel(16'd2, 16'h0001);
        load_pixel(16'd258, 16'hFFFF);
        sample_at(16'h0180, 16'h0080, 1'b0);
        sample_at(16'h01FF, 16'h0001, 1'b1);
        // off the right or lower edge
        sample_at(16'hFF00, 16'h0000, 1'b0);
        sample_at(16'h0000, 16'hFF00, 1'b1);
        sample_at(16'hFE00, 16'hFF00, 1'b0);
        sample_at(16'hFF00, 16'hFE00, 1'b0);
        sample_at(16'hFFFF, 16'hFFFF, 1'b1);
    endtask

    task automatic run_random(input int count);
        int          start, pick;
        int unsigned x0, y0;
        start = sent_count;
        while (sent_count - start < count)
        begin
            pick = $urandom_range(99);
            x0 = $urandom_range(cur_w - 2);
            y0 = $urandom_range(cur_h - 2);
            if (pick < 10)
                load_pixel(16'($urandom), 16'($urandom));
            else if (pick < 16)
            begin
                x0 = $urandom_range(255, cur_w - 1);
                sample_at({8'(x0), 8'($urandom)}, {8'(y0), 8'($urandom)},
                          1'($urandom_range(1)));
            end
            else if (pick < 22)
            begin
                y0 = $urandom_range(255, cur_h - 1);
                sample_at({8'(x0), 8'($urandom)}, {8'(y0), 8'($urandom)},
                          1'($urandom_range(1)));
            end
            else if (pick < 27)
                sample_at(16'($urandom), 16'($urandom), 1'($urandom_range(1)));
            else
                sample_at({8'(x0), 8'($urandom)}, {8'(y0), 8'($urandom)},
                          1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        cmd_valid      <= 1'b0;
        cmd            <= '0;
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_ROW_WIDTH;
        cfg_data       <= '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        sent_count     = 0;
        cur_w          = 256;
        cur_h          = 256;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (int phase = 0; phase < 8; phase++)
        begin
            drain();
            set_shape(shape_w[phase], shape_h[phase]);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            // let the block back up against a stalled output
            if (phase == 4)
                hold_cycles = 300;
            run_random(85);
        end

        drain();
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
